@@ rtl/lcg_pkg.sv @@
package lcg_pkg;

    // Fixed sizing of the synthesizer.
    localparam int MAX_SAMPLES    = 8192;
    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int COUNT_RESET    = 4800;

    // Widths of the configuration registers and the result word.
    localparam int START_W  = 31;
    localparam int STEP_W   = 32;
    localparam int SCOUNT_W = 14;
    localparam int CFG_W    = 32;
    localparam int SAMPLE_W = 16;
    localparam int MAG_BITS = SAMPLE_W - 1;

    // Counter that can also hold the chirp length itself.
    localparam int CNT_BITS = $clog2(MAX_SAMPLES + 1);

    // Quarter-wave table geometry.
    localparam int QUARTER   = 1 << (SINE_ADDR_BITS - 2);
    localparam int QADDR_W   = SINE_ADDR_BITS - 2;
    localparam int K_W       = SINE_ADDR_BITS - 1;

    // Q30 fixed point used while building the table.
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint C1  = 64'sd1686629713;
    localparam longint C3  = -64'sd693598668;
    localparam longint C5  = 64'sd85569306;
    localparam longint C7  = -64'sd5026995;
    localparam longint C9  = 64'sd172271;
    localparam longint C11 = -64'sd3864;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_FREQ   = 2'd0,
        CFG_FREQ_STEP    = 2'd1,
        CFG_SAMPLE_COUNT = 2'd2
    } cfg_idx_t;

    typedef logic [MAG_BITS-1:0] mag_t;
    typedef logic [QUARTER-1:0][MAG_BITS-1:0] sine_rom_t;

    // Q30 product, truncated toward zero.
    function automatic longint qmul(input longint a, input longint b);
        return (a * b) / Q30_ONE;
    endfunction

    // Magnitude of the sine at quarter-wave position k, in Q15.
    function automatic mag_t sine_mag(input int k);
        longint t;
        longint u;
        longint p;
        longint s;
        longint mag;
        t = longint'(k) <<< (32 - SINE_ADDR_BITS);
        u = qmul(t, t);
        p = C11;
        p = C9 + qmul(u, p);
        p = C7 + qmul(u, p);
        p = C5 + qmul(u, p);
        p = C3 + qmul(u, p);
        p = C1 + qmul(u, p);
        s = qmul(t, p);
        if (s < 0) begin
            s = 0;
        end
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        mag = (s * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
        return mag[MAG_BITS-1:0];
    endfunction

    // Quarter-wave table for positions 0 to QUARTER-1.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < QUARTER; i++) begin
            rom[i] = sine_mag(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM  = build_sine_rom();
    // The peak of the wave sits just past the end of the table.
    localparam mag_t      SINE_PEAK = sine_mag(QUARTER);

endpackage

@@ rtl/linear_chirp_generator.sv @@
// Channel   | Direction | Ports                                   | Meaning
// ----------+-----------+-----------------------------------------+---------------------------
// input     | in        | s_valid, s_ready, s_restart             | one tick per word
// result    | out       | m_valid, m_ready, m_sample, m_last,     | one sample word per tick
//           |           | m_done_res                              |
// config    | in        | cfg_wr_en, cfg_addr, cfg_wdata          | register writes, no wait
//
// Each tick is turned into its sample in the cycle it is accepted and the word appears
// in the output register in the next cycle; one tick per clock is sustained with m_ready high.
// The phase add and the quarter-wave table read form the single stage.
// A stalled output register holds its word; a new tick is taken in the same cycle the
// held word leaves. Reset (aresetn, synchronous) leaves the chirp finished.
module linear_chirp_generator
    import lcg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_addr,
    input  logic [CFG_W-1:0]           cfg_wdata,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_restart,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample,
    output logic                       m_last,
    output logic                       m_done_res
);

    localparam logic [CNT_BITS-1:0] RESET_LEN = CNT_BITS'(COUNT_RESET);

    // Configuration registers.
    logic [START_W-1:0]         start_freq_reg;
    logic signed [STEP_W-1:0]   freq_step_reg;
    logic [SCOUNT_W-1:0]        sample_count_reg;

    // Synthesizer state.
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic [PHASE_BITS-1:0]      freq_reg, freq_next;
    logic [CNT_BITS-1:0]        sample_index_reg, sample_index_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_done_reg, out_done_next;

    logic                       accept;
    logic [CNT_BITS-1:0]        len;
    logic [PHASE_BITS-1:0]      phase_cur;
    logic [PHASE_BITS-1:0]      freq_cur;
    logic [CNT_BITS-1:0]        index_cur;
    logic                       active;
    logic [SINE_ADDR_BITS-1:0]  sine_addr;
    logic [K_W-1:0]             quarter_pos;
    mag_t                       mag;

    assign accept  = s_valid && s_ready;
    assign s_ready = !out_valid_reg || m_ready;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_freq_reg   <= '0;
            freq_step_reg    <= '0;
            sample_count_reg <= SCOUNT_W'(COUNT_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_START_FREQ:   start_freq_reg   <= cfg_wdata[START_W-1:0];
                CFG_FREQ_STEP:    freq_step_reg    <= cfg_wdata[STEP_W-1:0];
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[SCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective chirp length: zero acts as one, long counts saturate.
    always_comb begin
        if (sample_count_reg == '0) begin
            len = CNT_BITS'(1);
        end else if (sample_count_reg > SCOUNT_W'(MAX_SAMPLES)) begin
            len = CNT_BITS'(MAX_SAMPLES);
        end else begin
            len = CNT_BITS'(sample_count_reg);
        end
    end

    // A restart tick reloads the state before its sample is formed.
    always_comb begin
        if (s_restart) begin
            phase_cur = '0;
            freq_cur  = PHASE_BITS'(start_freq_reg);
            index_cur = '0;
        end else begin
            phase_cur = phase_reg;
            freq_cur  = freq_reg;
            index_cur = sample_index_reg;
        end
        active = index_cur < len;
    end

    // Quarter-wave lookup: the second bit of the quadrant mirrors the address,
    // the top bit negates the result.
    assign sine_addr = phase_cur[PHASE_BITS-1 -: SINE_ADDR_BITS];

    always_comb begin
        if (sine_addr[QADDR_W]) begin
            quarter_pos = K_W'(QUARTER) - K_W'(sine_addr[QADDR_W-1:0]);
        end else begin
            quarter_pos = K_W'(sine_addr[QADDR_W-1:0]);
        end
        if (quarter_pos[K_W-1]) begin
            mag = SINE_PEAK;
        end else begin
            mag = SINE_ROM[quarter_pos[QADDR_W-1:0]];
        end
    end

    // Next state and next output word.
    always_comb begin
        phase_next        = phase_reg;
        freq_next         = freq_reg;
        sample_index_next = sample_index_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        out_sample_next   = out_sample_reg;
        out_last_next     = out_last_reg;
        out_done_next     = out_done_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            if (active) begin
                if (sine_addr[SINE_ADDR_BITS-1]) begin
                    out_sample_next = -$signed({1'b0, mag});
                end else begin
                    out_sample_next = $signed({1'b0, mag});
                end
                out_last_next     = (index_cur == len - CNT_BITS'(1));
                out_done_next     = 1'b0;
                phase_next        = phase_cur + freq_cur;
                freq_next         = freq_cur + PHASE_BITS'(freq_step_reg);
                sample_index_next = index_cur + CNT_BITS'(1);
            end else begin
                out_sample_next = '0;
                out_last_next   = 1'b0;
                out_done_next   = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= '0;
            freq_reg         <= '0;
            sample_index_reg <= RESET_LEN;
            out_valid_reg    <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            freq_reg         <= freq_next;
            sample_index_reg <= sample_index_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_sample   = out_sample_reg;
    assign m_last     = out_last_reg;
    assign m_done_res = out_done_reg;

    // A finished chirp answers with a silent word.
    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_sample == '0 && !m_last)
        else $error("done word carries a sample or last flag");

    // A restart always produces a live sample.
    a_restart_live: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_restart |=> m_valid && !m_done_res)
        else $error("restart tick produced a done word");

    // Ticks after the end leave the synthesizer state alone.
    a_done_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_restart && sample_index_reg >= len
        |=> $stable(phase_reg) && $stable(freq_reg) && $stable(sample_index_reg))
        else $error("state moved after the chirp finished");

    // The sample counter never runs past the longest chirp.
    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_index_reg <= CNT_BITS'(MAX_SAMPLES))
        else $error("sample counter out of range");

endmodule
